/* hw/rtl/cldcp_pkg.sv */
// ----------------------------------------------------------------------------
// cldcp_pkg
// Shared constants and types for the colon list decimal clamp parser.
// ----------------------------------------------------------------------------
package cldcp_pkg;

    // Frame limits
    localparam int MAX_CHIPS      = 256;
    localparam int MAX_TEXT_BYTES = 4096;

    // Cap applied to the chip limit register, at the width of the register
    localparam logic [8:0] CHIP_CAP = 9'(MAX_CHIPS);

    // Ignored token counter saturates here
    localparam logic [11:0] IGN_SAT = 12'hfff;

    // Token phase codes
    localparam logic [1:0] PH_SPACE  = 2'd0;
    localparam logic [1:0] PH_DIGITS = 2'd1;
    localparam logic [1:0] PH_SKIP   = 2'd2;

    // Summary status codes
    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_MINMAX = 2'd1;
    localparam logic [1:0] ST_LONG   = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] CFG_CHIP_LIMIT = 2'd0;
    localparam logic [1:0] CFG_MIN_FREQ   = 2'd1;
    localparam logic [1:0] CFG_MAX_FREQ   = 2'd2;

    // Characters
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_COLON = 8'h3a;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0d;
    localparam logic [7:0] CH_PLUS  = 8'h2b;
    localparam logic [7:0] CH_MINUS = 8'h2d;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    // Largest magnitudes for a positive and a negative value
    localparam logic [35:0] LIMIT_POS = 36'h0_7fff_ffff;
    localparam logic [35:0] LIMIT_NEG = 36'h0_8000_0000;

    // Result queue depth
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // One result item
    typedef struct packed {
        logic               is_summary;
        logic [7:0]         chip_index;
        logic signed [31:0] frequency;
        logic [8:0]         parsed_count;
        logic [12:0]        ignored_count;
        logic [8:0]         zero_count;
        logic [8:0]         low_clamp_count;
        logic [8:0]         high_clamp_count;
        logic [1:0]         status;
    } out_item_t;

endpackage

/* hw/rtl/colon_list_decimal_clamp_parser_unit.sv */
// ----------------------------------------------------------------------------
// colon_list_decimal_clamp_parser_unit
// Splits a byte stream into colon-separated decimal tokens, clamps the values
// and closes each frame with a summary item.
// ----------------------------------------------------------------------------
// Usage:
//   s_* carries one text byte per item; s_tlast marks the last byte of a
//   frame. m_* carries value items (m_tuser = 0) and one summary item per
//   frame (m_tuser = 1, m_tlast = 1). cfg_* writes the chip limit, min_freq
//   and max_freq by index; it is always ready. The user must write only
//   while idle; the block itself does not enforce this. Each byte is taken
//   into an input register and handled from there, once the queue has room,
//   by one pass of logic (a times-ten shift-add, one overflow compare and
//   the clamp compares) that pushes up to two items into a four-entry result
//   queue, whose count drives m_tvalid. Throughput is one byte per cycle
//   while the queue has two free entries; the output port moves one item
//   per cycle while m_tready is high, so the last byte of a frame that
//   closes a token yields two items that leave one after the other. The
//   input register is held while the queue has fewer than two free entries,
//   so a stalled receiver backs up s_tready without losing items.
//   Reset clears the token and frame state, the configuration registers and
//   the queue; s_tready is high in the first cycle after reset.
// ----------------------------------------------------------------------------
module colon_list_decimal_clamp_parser_unit #(
    parameter int MAX_TEXT_BYTES = cldcp_pkg::MAX_TEXT_BYTES
) (
    input  logic        aclk,
    input  logic        aresetn,
    // Input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] text_byte
    input  logic        s_tlast,   // frame_end
    // Result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [95:0] m_tdata,   // [7:0] chip_index, [39:8] frequency,
                                   // [48:40] parsed_count, [61:49] ignored_count,
                                   // [70:62] zero_count, [79:71] low_clamp_count,
                                   // [88:80] high_clamp_count, [90:89] status,
                                   // [95:91] zero
    output logic        m_tuser,   // is_summary
    output logic        m_tlast,   // last
    // Configuration writes
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    localparam int BW = $clog2(MAX_TEXT_BYTES + 2);
    localparam logic [BW-1:0] BYTE_MAX = BW'(MAX_TEXT_BYTES);

    // Configuration registers
    logic [8:0]         chip_limit_reg;
    logic signed [31:0] min_freq_reg;
    logic signed [31:0] max_freq_reg;

    // Input register
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       in_last_reg;

    // Token and frame state
    logic [1:0]    phase_reg,   phase_next;
    logic          neg_reg,     neg_next;
    logic [31:0]   acc_reg,     acc_next;
    logic          ovf_reg,     ovf_next;
    logic          open_reg,    open_next;
    logic          ended_reg,   ended_next;
    logic [BW-1:0] bytes_reg,   bytes_next;
    logic [8:0]    parsed_reg,  parsed_next;
    logic [11:0]   ignored_reg, ignored_next;
    logic [8:0]    zero_reg,    zero_next;
    logic [8:0]    low_reg,     low_next;
    logic [8:0]    high_reg,    high_next;

    // Result queue
    cldcp_pkg::out_item_t    q_mem [cldcp_pkg::QDEPTH];
    logic [cldcp_pkg::QPTR_W-1:0] q_head_reg;
    logic [cldcp_pkg::QPTR_W-1:0] q_tail_reg;
    logic [cldcp_pkg::QCNT_W-1:0] q_count_reg;

    // Pass logic
    logic                 proc_fire;
    logic                 s_fire;
    logic                 m_fire;
    logic                 is_digit;
    logic                 is_blank;
    logic                 is_sep;
    logic [3:0]           digit;
    logic [35:0]          limit;
    logic [35:0]          acc_x10_d;
    logic [1:0]           t_phase;
    logic                 t_neg;
    logic [31:0]          t_acc;
    logic                 t_ovf;
    logic                 t_open;
    logic                 close_req;
    logic                 do_close;
    logic                 emit;
    logic [8:0]           cap;
    logic signed [32:0]   mag;
    logic signed [32:0]   sval;
    logic signed [32:0]   lo_ext;
    logic signed [32:0]   hi_ext;
    logic                 val_zero;
    logic signed [31:0]   freq;
    logic [1:0]           sum_status;
    cldcp_pkg::out_item_t val_item;
    cldcp_pkg::out_item_t sum_item;
    cldcp_pkg::out_item_t push0_item;
    logic                 push0;
    logic                 push1;

    assign cfg_ready = 1'b1;

    // Handshakes
    assign proc_fire = in_valid_reg && (q_count_reg <= cldcp_pkg::QCNT_W'(cldcp_pkg::QDEPTH - 2));
    assign s_tready  = !in_valid_reg || proc_fire;
    assign s_fire    = s_tvalid && s_tready;
    assign m_tvalid  = (q_count_reg != '0);
    assign m_fire    = m_tvalid && m_tready;

    // Classify the byte
    always_comb begin
        is_digit  = (in_byte_reg >= cldcp_pkg::CH_ZERO) && (in_byte_reg <= cldcp_pkg::CH_NINE);
        is_blank  = (in_byte_reg == cldcp_pkg::CH_SPACE) ||
                    ((in_byte_reg >= cldcp_pkg::CH_TAB) && (in_byte_reg <= cldcp_pkg::CH_CR));
        is_sep    = (in_byte_reg == cldcp_pkg::CH_NUL) || (in_byte_reg == cldcp_pkg::CH_COLON);
        digit     = 4'(in_byte_reg - cldcp_pkg::CH_ZERO);
        limit     = neg_reg ? cldcp_pkg::LIMIT_NEG : cldcp_pkg::LIMIT_POS;
        acc_x10_d = ({4'b0, acc_reg} << 3) + ({4'b0, acc_reg} << 1) + {32'b0, digit};
    end

    // Advance the token with this byte
    always_comb begin
        t_phase    = phase_reg;
        t_neg      = neg_reg;
        t_acc      = acc_reg;
        t_ovf      = ovf_reg;
        t_open     = open_reg;
        ended_next = ended_reg;
        if (!ended_reg) begin
            if (in_byte_reg == cldcp_pkg::CH_NUL) begin
                ended_next = 1'b1;
            end else if (in_byte_reg != cldcp_pkg::CH_COLON) begin
                t_open = 1'b1;
                unique case (phase_reg)
                    cldcp_pkg::PH_SPACE: begin
                        if (is_blank) begin
                            t_phase = cldcp_pkg::PH_SPACE;
                        end else if (in_byte_reg == cldcp_pkg::CH_PLUS ||
                                     in_byte_reg == cldcp_pkg::CH_MINUS) begin
                            t_neg   = (in_byte_reg == cldcp_pkg::CH_MINUS);
                            t_phase = cldcp_pkg::PH_DIGITS;
                        end else if (is_digit) begin
                            t_phase = cldcp_pkg::PH_DIGITS;
                        end else begin
                            t_phase = cldcp_pkg::PH_SKIP;
                        end
                    end
                    cldcp_pkg::PH_DIGITS: begin
                        if (!is_digit) begin
                            t_phase = cldcp_pkg::PH_SKIP;
                        end
                    end
                    default: begin
                        t_phase = phase_reg;
                    end
                endcase
                // Take a digit, or drop the value on overflow
                if (is_digit && !ovf_reg &&
                    (phase_reg == cldcp_pkg::PH_SPACE || phase_reg == cldcp_pkg::PH_DIGITS)) begin
                    if (acc_x10_d > limit) begin
                        t_ovf = 1'b1;
                        t_acc = '0;
                    end else begin
                        t_acc = acc_x10_d[31:0];
                    end
                end
            end
        end
    end

    // Close the token, clamp and count
    always_comb begin
        close_req = (!ended_reg && is_sep) || in_last_reg;
        do_close  = close_req && t_open;
        cap       = (chip_limit_reg > cldcp_pkg::CHIP_CAP) ? cldcp_pkg::CHIP_CAP : chip_limit_reg;
        emit      = do_close && (parsed_reg < cap);
        mag       = signed'({1'b0, t_acc});
        sval      = t_neg ? -mag : mag;
        lo_ext    = 33'(min_freq_reg);
        hi_ext    = 33'(max_freq_reg);
        val_zero  = (t_acc == '0);

        parsed_next  = parsed_reg;
        ignored_next = ignored_reg;
        zero_next    = zero_reg;
        low_next     = low_reg;
        high_next    = high_reg;
        freq         = sval[31:0];

        if (do_close && !emit) begin
            if (ignored_reg < cldcp_pkg::IGN_SAT) begin
                ignored_next = ignored_reg + 12'd1;
            end
        end
        if (emit) begin
            parsed_next = parsed_reg + 9'd1;
            if (val_zero) begin
                zero_next = zero_reg + 9'd1;
            end else if (sval < lo_ext) begin
                freq     = min_freq_reg;
                low_next = low_reg + 9'd1;
            end else if (sval > hi_ext) begin
                freq      = max_freq_reg;
                high_next = high_reg + 9'd1;
            end
        end

        bytes_next = (bytes_reg <= BYTE_MAX) ? bytes_reg + 1'b1 : bytes_reg;

        if (min_freq_reg > max_freq_reg) begin
            sum_status = cldcp_pkg::ST_MINMAX;
        end else if (bytes_next > BYTE_MAX) begin
            sum_status = cldcp_pkg::ST_LONG;
        end else begin
            sum_status = cldcp_pkg::ST_OK;
        end
    end

    // Build the result items
    always_comb begin
        val_item            = '0;
        val_item.chip_index = parsed_reg[7:0];
        val_item.frequency  = freq;

        sum_item            = '0;
        sum_item.is_summary = 1'b1;
        sum_item.status     = sum_status;
        if (sum_status == cldcp_pkg::ST_OK) begin
            sum_item.parsed_count     = parsed_next;
            sum_item.ignored_count    = {1'b0, ignored_next};
            sum_item.zero_count       = zero_next;
            sum_item.low_clamp_count  = low_next;
            sum_item.high_clamp_count = high_next;
        end

        push0      = proc_fire && (emit || in_last_reg);
        push1      = proc_fire && emit && in_last_reg;
        push0_item = emit ? val_item : sum_item;
    end

    // Next token state: clear after a close or after the frame's last byte
    always_comb begin
        phase_next = t_phase;
        neg_next   = t_neg;
        acc_next   = t_acc;
        ovf_next   = t_ovf;
        open_next  = t_open;
        if (do_close || in_last_reg) begin
            phase_next = cldcp_pkg::PH_SPACE;
            neg_next   = 1'b0;
            acc_next   = '0;
            ovf_next   = 1'b0;
            open_next  = 1'b0;
        end
    end

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            chip_limit_reg <= '0;
            min_freq_reg   <= '0;
            max_freq_reg   <= '0;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                cldcp_pkg::CFG_CHIP_LIMIT: chip_limit_reg <= cfg_data[8:0];
                cldcp_pkg::CFG_MIN_FREQ:   min_freq_reg   <= signed'(cfg_data);
                cldcp_pkg::CFG_MAX_FREQ:   max_freq_reg   <= signed'(cfg_data);
                default: begin
                end
            endcase
        end
    end

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= s_fire || (in_valid_reg && !proc_fire);
        end
        if (s_fire) begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    // Token and frame state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= cldcp_pkg::PH_SPACE;
            neg_reg     <= 1'b0;
            acc_reg     <= '0;
            ovf_reg     <= 1'b0;
            open_reg    <= 1'b0;
            ended_reg   <= 1'b0;
            bytes_reg   <= '0;
            parsed_reg  <= '0;
            ignored_reg <= '0;
            zero_reg    <= '0;
            low_reg     <= '0;
            high_reg    <= '0;
        end else if (proc_fire) begin
            phase_reg <= phase_next;
            neg_reg   <= neg_next;
            acc_reg   <= acc_next;
            ovf_reg   <= ovf_next;
            open_reg  <= open_next;
            if (in_last_reg) begin
                ended_reg   <= 1'b0;
                bytes_reg   <= '0;
                parsed_reg  <= '0;
                ignored_reg <= '0;
                zero_reg    <= '0;
                low_reg     <= '0;
                high_reg    <= '0;
            end else begin
                ended_reg   <= ended_next;
                bytes_reg   <= bytes_next;
                parsed_reg  <= parsed_next;
                ignored_reg <= ignored_next;
                zero_reg    <= zero_next;
                low_reg     <= low_next;
                high_reg    <= high_next;
            end
        end
    end

    // Result queue storage
    always_ff @(posedge aclk) begin
        if (push0) begin
            q_mem[q_tail_reg] <= push0_item;
        end
        if (push1) begin
            q_mem[q_tail_reg + 1'b1] <= sum_item;
        end
    end

    // Result queue pointers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            q_head_reg  <= '0;
            q_tail_reg  <= '0;
            q_count_reg <= '0;
        end else begin
            q_tail_reg  <= q_tail_reg + cldcp_pkg::QPTR_W'(push0) + cldcp_pkg::QPTR_W'(push1);
            q_head_reg  <= q_head_reg + cldcp_pkg::QPTR_W'(m_fire);
            q_count_reg <= q_count_reg + cldcp_pkg::QCNT_W'(push0) + cldcp_pkg::QCNT_W'(push1)
                           - cldcp_pkg::QCNT_W'(m_fire);
        end
    end

    // Drive the result port from the queue head
    always_comb begin
        m_tdata = {5'b0,
                   q_mem[q_head_reg].status,
                   q_mem[q_head_reg].high_clamp_count,
                   q_mem[q_head_reg].low_clamp_count,
                   q_mem[q_head_reg].zero_count,
                   q_mem[q_head_reg].ignored_count,
                   q_mem[q_head_reg].parsed_count,
                   q_mem[q_head_reg].frequency,
                   q_mem[q_head_reg].chip_index};
        m_tuser = q_mem[q_head_reg].is_summary;
        m_tlast = q_mem[q_head_reg].is_summary;
    end

endmodule

/* sim/colon_list_decimal_clamp_parser_unit_test.sv */
// ----------------------------------------------------------------------------
// colon_list_decimal_clamp_parser_unit_test
// Self-checking bench for the colon list parser. Directed frames cover token
// rules, 32-bit limits, clamp bounds and the chip cap.
// Random frames with random settings follow. A built-in tokenizer predicts
// every value and summary item, and each result is checked in order.
// ----------------------------------------------------------------------------
module colon_list_decimal_clamp_parser_unit_test;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int TEXT_LIMIT  = cldcp_pkg::MAX_TEXT_BYTES;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int RANDOM_BYTES = 1000;
    localparam int RX_MAX_STALL = 6;

    // Register index with no register behind it
    localparam logic [1:0] CFG_UNUSED = 2'd3;

    // Extra whitespace characters
    localparam logic [7:0] CH_LF = 8'h0a;
    localparam logic [7:0] CH_VT = 8'h0b;
    localparam logic [7:0] CH_FF = 8'h0c;

    localparam logic [31:0] INT_MIN = 32'h8000_0000;
    localparam logic [31:0] INT_MAX = 32'h7fff_ffff;

    logic        aclk;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata   = '0;
    logic        s_tlast   = 1'b0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [95:0] m_tdata;
    logic        m_tuser;
    logic        m_tlast;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic [31:0] cfg_data  = '0;

    colon_list_decimal_clamp_parser_unit #(
        .MAX_TEXT_BYTES(TEXT_LIMIT)
    ) i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // 8 ns clock
    always begin
        aclk = 1'b0;
        #4;
        aclk = 1'b1;
        #4;
    end

    // ------------------------------------------------------------------------
    // Tokenizer state mirrored by the bench
    // ------------------------------------------------------------------------
    logic [8:0]         chips_per_frame = '0;
    logic signed [31:0] freq_floor      = '0;
    logic signed [31:0] freq_ceiling    = '0;

    logic [1:0]  tok_phase;
    logic        tok_negative;
    logic [31:0] tok_magnitude;
    logic        tok_overflow;
    logic        tok_open;
    logic        text_done;
    logic [12:0] frame_bytes;
    logic [8:0]  n_parsed;
    logic [11:0] n_ignored;
    logic [8:0]  n_zero;
    logic [8:0]  n_low;
    logic [8:0]  n_high;

    cldcp_pkg::out_item_t frame_items_due[$];

    int mismatches  = 0;
    int cycle_count = 0;

    // Stream pacing knobs
    int tx_burst_left = 0;
    int tx_max_gap    = 0;
    int rx_ready_pct  = 100;
    int rx_hold       = 0;

    function automatic void clear_token();
        tok_phase     = cldcp_pkg::PH_SPACE;
        tok_negative  = 1'b0;
        tok_magnitude = '0;
        tok_overflow  = 1'b0;
        tok_open      = 1'b0;
    endfunction

    function automatic void clear_frame();
        clear_token();
        text_done   = 1'b0;
        frame_bytes = '0;
        n_parsed    = '0;
        n_ignored   = '0;
        n_zero      = '0;
        n_low       = '0;
        n_high      = '0;
    endfunction

    // Fold one decimal digit into the magnitude, flag overflow past the signed 32-bit limit
    function automatic void take_digit(int unsigned d);
        longint lim;
        lim = tok_negative ? 64'd2147483648 : 64'd2147483647;
        if (tok_overflow)
            return;
        if (longint'({32'b0, tok_magnitude}) > (lim - d) / 10) begin
            tok_overflow  = 1'b1;
            tok_magnitude = '0;
        end else begin
            tok_magnitude = tok_magnitude * 10 + d;
        end
    endfunction

    // Finish the open token: emit a clamped value or count it as ignored
    function automatic void close_token();
        logic [8:0]           cap;
        longint               v;
        cldcp_pkg::out_item_t it;
        if (!tok_open)
            return;
        cap = (chips_per_frame > cldcp_pkg::CHIP_CAP) ? cldcp_pkg::CHIP_CAP : chips_per_frame;
        if (n_parsed >= cap) begin
            if (n_ignored < cldcp_pkg::IGN_SAT)
                n_ignored++;
            clear_token();
            return;
        end
        v = tok_overflow ? 0 : longint'({32'b0, tok_magnitude});
        if (tok_negative)
            v = -v;
        if (v == 0) begin
            n_zero++;
        end else if (v < freq_floor) begin
            v = freq_floor;
            n_low++;
        end else if (v > freq_ceiling) begin
            v = freq_ceiling;
            n_high++;
        end
        it            = '0;
        it.chip_index = n_parsed[7:0];
        it.frequency  = v[31:0];
        frame_items_due.push_back(it);
        n_parsed++;
        clear_token();
    endfunction

    // Advance the tokenizer by one text byte and queue the items it yields
    function automatic void parse_text_byte(logic [7:0] b, logic frame_end);
        logic                 is_digit;
        logic                 is_blank;
        cldcp_pkg::out_item_t sum;
        is_digit = (b >= cldcp_pkg::CH_ZERO) && (b <= cldcp_pkg::CH_NINE);
        is_blank = (b == cldcp_pkg::CH_SPACE) ||
                   (b >= cldcp_pkg::CH_TAB && b <= cldcp_pkg::CH_CR);
        if (frame_bytes <= TEXT_LIMIT)
            frame_bytes++;
        if (!text_done) begin
            if (b == cldcp_pkg::CH_NUL) begin
                text_done = 1'b1;
                close_token();
            end else if (b == cldcp_pkg::CH_COLON) begin
                close_token();
            end else begin
                tok_open = 1'b1;
                case (tok_phase)
                    cldcp_pkg::PH_SPACE: begin
                        if (b == cldcp_pkg::CH_PLUS || b == cldcp_pkg::CH_MINUS) begin
                            tok_negative = (b == cldcp_pkg::CH_MINUS);
                            tok_phase    = cldcp_pkg::PH_DIGITS;
                        end else if (is_digit) begin
                            take_digit(b - cldcp_pkg::CH_ZERO);
                            tok_phase = cldcp_pkg::PH_DIGITS;
                        end else if (!is_blank) begin
                            tok_phase = cldcp_pkg::PH_SKIP;
                        end
                    end
                    cldcp_pkg::PH_DIGITS: begin
                        if (is_digit)
                            take_digit(b - cldcp_pkg::CH_ZERO);
                        else
                            tok_phase = cldcp_pkg::PH_SKIP;
                    end
                    default: ;
                endcase
            end
        end
        if (frame_end) begin
            close_token();
            sum            = '0;
            sum.is_summary = 1'b1;
            if (freq_floor > freq_ceiling) begin
                sum.status = cldcp_pkg::ST_MINMAX;
            end else if (frame_bytes > TEXT_LIMIT) begin
                sum.status = cldcp_pkg::ST_LONG;
            end else begin
                sum.parsed_count     = n_parsed;
                sum.ignored_count    = {1'b0, n_ignored};
                sum.zero_count       = n_zero;
                sum.low_clamp_count  = n_low;
                sum.high_clamp_count = n_high;
                sum.status           = cldcp_pkg::ST_OK;
            end
            frame_items_due.push_back(sum);
            clear_frame();
        end
    endfunction

    function automatic string fmt_item(cldcp_pkg::out_item_t it, logic last, logic [4:0] pad);
        return $sformatf({"sum=%0b idx=%0d freq=%0d parsed=%0d ign=%0d zero=%0d ",
                          "low=%0d high=%0d st=%0d last=%0b pad=%0h"},
                         it.is_summary, it.chip_index, it.frequency, it.parsed_count,
                         it.ignored_count, it.zero_count, it.low_clamp_count,
                         it.high_clamp_count, it.status, last, pad);
    endfunction

    // ------------------------------------------------------------------------
    // Result checker: an item seen with valid and ready at the falling edge
    // is taken at the next rising edge
    // ------------------------------------------------------------------------
    always @(negedge aclk) begin
        cldcp_pkg::out_item_t got;
        cldcp_pkg::out_item_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got.is_summary       = m_tuser;
            got.chip_index       = m_tdata[7:0];
            got.frequency        = m_tdata[39:8];
            got.parsed_count     = m_tdata[48:40];
            got.ignored_count    = m_tdata[61:49];
            got.zero_count       = m_tdata[70:62];
            got.low_clamp_count  = m_tdata[79:71];
            got.high_clamp_count = m_tdata[88:80];
            got.status           = m_tdata[90:89];
            if (frame_items_due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: unexpected item %s",
                             fmt_item(got, m_tlast, m_tdata[95:91]));
            end else begin
                want = frame_items_due.pop_front();
                if (got != want || m_tlast != want.is_summary || m_tdata[95:91] != '0) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("ERROR: item mismatch at cycle %0d", cycle_count);
                        $display("  expected %s", fmt_item(want, want.is_summary, 5'd0));
                        $display("  actual   %s", fmt_item(got, m_tlast, m_tdata[95:91]));
                    end
                end
            end
        end
    end

    // Receiver: ready at the rate set by rx_ready_pct, with stalls of random length
    always @(posedge aclk) begin
        if (rx_hold > 0) begin
            m_tready <= 1'b0;
            rx_hold  = rx_hold - 1;
        end else if ($urandom_range(99) < rx_ready_pct) begin
            m_tready <= 1'b1;
        end else begin
            m_tready <= 1'b0;
            rx_hold  = $urandom_range(RX_MAX_STALL - 1);
        end
    end

    // Watchdog
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("ERROR: timeout with %0d items outstanding", frame_items_due.size());
            $display("DONE: errors detected");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------

    // Write one register and update the mirrored settings
    task automatic write_reg(logic [1:0] idx, logic [31:0] val);
        bit taken;
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do begin
            @(negedge aclk);
            taken = cfg_ready;
            @(posedge aclk);
        end while (!taken);
        cfg_valid <= 1'b0;
        @(posedge aclk);
        case (idx)
            cldcp_pkg::CFG_CHIP_LIMIT: chips_per_frame = val[8:0];
            cldcp_pkg::CFG_MIN_FREQ:   freq_floor      = val;
            cldcp_pkg::CFG_MAX_FREQ:   freq_ceiling    = val;
            default: ;
        endcase
    endtask

    task automatic configure(logic [8:0] chips, logic [31:0] lo, logic [31:0] hi);
        write_reg(cldcp_pkg::CFG_CHIP_LIMIT, {23'b0, chips});
        write_reg(cldcp_pkg::CFG_MIN_FREQ, lo);
        write_reg(cldcp_pkg::CFG_MAX_FREQ, hi);
    endtask

    // Send one text byte in bursts with random gaps, then predict its items
    task automatic send_text_byte(logic [7:0] b, logic frame_end);
        int  gap;
        bit  taken;
        if (tx_burst_left == 0) begin
            gap = $urandom_range(tx_max_gap);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            tx_burst_left = $urandom_range(16, 1);
        end
        tx_burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= frame_end;
        do begin
            @(negedge aclk);
            taken = s_tready;
            @(posedge aclk);
        end while (!taken);
        parse_text_byte(b, frame_end);
    endtask

    task automatic send_frame(ref logic [7:0] q[$]);
        for (int i = 0; i < q.size(); i++)
            send_text_byte(q[i], i == q.size() - 1);
    endtask

    // Stop sending and let every expected item come out
    task automatic drain();
        s_tvalid <= 1'b0;
        while (frame_items_due.size() != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    function automatic void push_text(ref logic [7:0] q[$], input string s);
        for (int i = 0; i < s.len(); i++)
            q.push_back(s[i]);
    endfunction

    function automatic logic [7:0] random_blank();
        return ($urandom_range(5) == 0) ? cldcp_pkg::CH_SPACE
                                        : cldcp_pkg::CH_TAB + 8'($urandom_range(4));
    endfunction

    // Decimal magnitude: small, zero, full range, near the 32-bit edge or huge
    function automatic void push_number(ref logic [7:0] q[$]);
        int unsigned r;
        r = $urandom_range(99);
        if ($urandom_range(7) == 0)
            repeat ($urandom_range(2, 1)) q.push_back(cldcp_pkg::CH_ZERO);
        if (r < 40)
            push_text(q, $sformatf("%0d", $urandom_range(999)));
        else if (r < 55)
            q.push_back(cldcp_pkg::CH_ZERO);
        else if (r < 75)
            push_text(q, $sformatf("%0d", $urandom()));
        else if (r < 90)
            push_text(q, $sformatf("%0d", 64'd2147483640 + $urandom_range(16)));
        else
            repeat ($urandom_range(20, 10))
                q.push_back(cldcp_pkg::CH_ZERO + 8'($urandom_range(9)));
    endfunction

    // One token: mostly numbers with an optional sign, some empty, sign-only or noise
    function automatic void push_token(ref logic [7:0] q[$]);
        int unsigned r;
        r = $urandom_range(99);
        if ($urandom_range(3) == 0)
            repeat ($urandom_range(3, 1)) q.push_back(random_blank());
        if (r < 8)
            return;
        if (r < 14) begin
            q.push_back($urandom_range(1) ? cldcp_pkg::CH_PLUS : cldcp_pkg::CH_MINUS);
            return;
        end
        if (r < 86) begin
            case ($urandom_range(2))
                0: q.push_back(cldcp_pkg::CH_PLUS);
                1: q.push_back(cldcp_pkg::CH_MINUS);
                default: ;
            endcase
            push_number(q);
            if ($urandom_range(4) == 0) begin
                q.push_back($urandom_range(1) ? random_blank() : 8'($urandom_range(255)));
                q.push_back(cldcp_pkg::CH_ZERO + 8'($urandom_range(9)));
            end
            return;
        end
        repeat ($urandom_range(4, 1)) q.push_back(8'($urandom_range(255)));
    endfunction

    function automatic void build_frame(ref logic [7:0] q[$]);
        int unsigned n;
        n = $urandom_range(8, 1);
        q.delete();
        for (int i = 0; i < n; i++) begin
            if (i != 0)
                q.push_back(cldcp_pkg::CH_COLON);
            push_token(q);
        end
        if ($urandom_range(3) == 0)
            q.push_back(cldcp_pkg::CH_COLON);
        if ($urandom_range(9) == 0) begin
            q.push_back(cldcp_pkg::CH_NUL);
            repeat ($urandom_range(3)) q.push_back(8'($urandom_range(255)));
        end
        if (q.size() == 0)
            q.push_back(8'($urandom_range(255)));
    endfunction

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Registers at reset: no chips, so every token is ignored
    task automatic test_reset_registers();
        logic [7:0] q[$];
        tx_max_gap   = 2;
        rx_ready_pct = 80;
        push_text(q, "12:-3");
        send_frame(q);
        drain();
    endtask

    // Whitespace, signs, junk after digits, empty tokens, NUL and frame ends
    task automatic test_token_rules();
        logic [7:0] q[$];
        configure(9'd16, -32'sd1000, 32'sd1000);
        q.push_back(cldcp_pkg::CH_SPACE);
        q.push_back(cldcp_pkg::CH_TAB);
        push_text(q, "+42:- 7:");
        q.push_back(CH_LF);
        q.push_back(CH_VT);
        q.push_back(CH_FF);
        q.push_back(cldcp_pkg::CH_CR);
        push_text(q, "13x::+:-: :0:0000:999999:-999999:abc");
        send_frame(q);
        q.delete();
        push_text(q, "8:9");
        q.push_back(cldcp_pkg::CH_NUL);
        send_frame(q);
        q.delete();
        q.push_back(cldcp_pkg::CH_COLON);
        send_frame(q);
        drain();
    endtask

    // Edges of the signed 32-bit range and overflow to zero
    task automatic test_int_limits();
        logic [7:0] q[$];
        configure(9'd511, INT_MIN, INT_MAX);
        push_text(q, "2147483647:-2147483648:2147483648:-2147483649:4294967296:");
        push_text(q, "00000000002147483647:+0:5");
        q.push_back(cldcp_pkg::CH_NUL);
        push_text(q, ":7:8");
        send_frame(q);
        drain();
    endtask

    // Floor above ceiling: values still come out, summary flags the error
    task automatic test_min_above_max();
        logic [7:0] q[$];
        configure(9'd2, 32'sd5, -32'sd5);
        push_text(q, "3:-3:0:9");
        send_frame(q);
        drain();
    endtask

    // A write to an unused index changes nothing
    task automatic test_unknown_register();
        logic [7:0] q[$];
        configure(9'd2, -32'sd10, 32'sd10);
        write_reg(CFG_UNUSED, $urandom());
        push_text(q, "1:-20:30");
        send_frame(q);
        drain();
    endtask

    // Oversized chip limit acts as the cap; slow receiver backs up the input
    task automatic test_chip_cap();
        logic [7:0] q[$];
        configure(9'd511, -32'sd10, 32'sd10);
        rx_ready_pct = 20;
        repeat (260) push_text(q, "0:");
        send_frame(q);
        drain();
        rx_ready_pct = 80;
    endtask

    // Random settings and pacing for the next run of frames
    task automatic random_setup();
        logic [8:0]  chips;
        logic [31:0] lo;
        logic [31:0] hi;
        int unsigned r;
        r = $urandom_range(99);
        if (r < 10)
            chips = 9'd0;
        else if (r < 70)
            chips = 9'($urandom_range(8, 1));
        else if (r < 85)
            chips = ($urandom_range(1) == 0) ? 9'd256 : 9'd511;
        else
            chips = 9'($urandom_range(511));
        r = $urandom_range(99);
        if (r < 60) begin
            lo = -int'($urandom_range(2000));
            hi = $urandom_range(2000);
        end else if (r < 75) begin
            lo = INT_MIN;
            hi = INT_MAX;
        end else if (r < 90) begin
            lo = $urandom();
            hi = $urandom();
        end else begin
            lo = $urandom_range(1000, 1);
            hi = -int'($urandom_range(1000));
        end
        configure(chips, lo, hi);
        case ($urandom_range(3))
            0: begin tx_max_gap = 0; rx_ready_pct = 100; end
            1: begin tx_max_gap = 2; rx_ready_pct = 85;  end
            2: begin tx_max_gap = 6; rx_ready_pct = 50;  end
            default: begin tx_max_gap = 1; rx_ready_pct = 25; end
        endcase
    endtask

    task automatic test_random_frames();
        logic [7:0] q[$];
        int sent;
        sent = 0;
        random_setup();
        while (sent < RANDOM_BYTES) begin
            if ($urandom_range(5) == 0) begin
                drain();
                random_setup();
            end
            build_frame(q);
            send_frame(q);
            sent += q.size();
        end
        drain();
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        clear_frame();
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_reset_registers();
        test_token_rules();
        test_int_limits();
        test_min_above_max();
        test_unknown_register();
        test_chip_cap();
        test_random_frames();
        if (mismatches == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

/* files.f */
hw/rtl/cldcp_pkg.sv
hw/rtl/colon_list_decimal_clamp_parser_unit.sv
sim/colon_list_decimal_clamp_parser_unit_test.sv
